@@ rtl/brbs_pkg.sv @@
// ----------------------------------------------------------------------------
// brbs_pkg
// Shared types and constants of the byte range block splitter.
// ----------------------------------------------------------------------------
package brbs_pkg;

  localparam int MAX_BLOCK_BYTES  = 4096;
  localparam int BLOCK_INDEX_BITS = 28;
  localparam int QW   = BLOCK_INDEX_BITS + 1;  // block counts up to 2**BLOCK_INDEX_BITS
  localparam int DIVW = 42;                    // byte addresses up to block_bytes * blocks
  localparam int CNTW = $clog2(DIVW);

  typedef enum logic [2:0] {
    CMD_FETCH    = 3'd0,
    CMD_WBACK    = 3'd1,
    CMD_BULK_RD  = 3'd2,
    CMD_BULK_WR  = 3'd3,
    CMD_TO_BUF   = 3'd4,
    CMD_TO_CACHE = 3'd5,
    CMD_DONE     = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_BLOCK_BYTES   = 2'd0,
    CFG_DEVICE_BLOCKS = 2'd1,
    CFG_WRITABLE      = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_CHECK,
    FR_DIV,
    FR_PUSH
  } front_state_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_HFETCH,
    BK_HCOPY,
    BK_HWB,
    BK_TFETCH,
    BK_TCOPY,
    BK_TWB,
    BK_BULK,
    BK_DONE
  } back_state_t;

  // Classified request handed from the front to the back.
  typedef struct packed {
    logic          wr;
    logic          reject;
    logic [31:0]   len;
    logic [12:0]   bsz;
    logic [QW-1:0] q1;   // start block
    logic [11:0]   r1;   // offset in start block
    logic [QW-1:0] q2;   // block holding the end byte address
    logic [11:0]   r2;   // offset of the end address in that block
  } plan_t;

endpackage

@@ rtl/brbs_front.sv @@
// ----------------------------------------------------------------------------
// brbs_front
// Accepts requests, checks and clamps them, and divides the start and end
// byte addresses by the block size one quotient bit per cycle.
// ----------------------------------------------------------------------------
module brbs_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 mode,
  input  logic [39:0]          byte_position,
  input  logic [31:0]          request_length,
  input  logic [12:0]          bsz,
  input  logic [brbs_pkg::QW-1:0] nblk,
  input  logic                 writable,
  input  logic                 full,
  output logic                 push,
  output brbs_pkg::plan_t      push_plan
);

  localparam int DIVW = brbs_pkg::DIVW;
  localparam int QW   = brbs_pkg::QW;

  brbs_pkg::front_state_t state, state_next;

  logic                      wr;
  logic [39:0]               pos;
  logic [31:0]               len;
  logic                      reject;
  logic [DIVW-1:0]           dev;
  logic [DIVW-1:0]           dev_next;
  logic [QW-1:0]             nblk_sat;
  logic [12:0]               rem_a, rem_b;
  logic [DIVW-1:0]           dvd_a, dvd_b;
  logic [brbs_pkg::CNTW-1:0] cnt;

  logic [DIVW-1:0] pos_w, end_full, end_c;
  logic [31:0]     len_c;
  logic            reject_c;
  logic [13:0]     ta, tb;
  logic            ge_a, ge_b;

  always_comb begin
    nblk_sat = (nblk > (QW'(1) << brbs_pkg::BLOCK_INDEX_BITS)) ?
               (QW'(1) << brbs_pkg::BLOCK_INDEX_BITS) : nblk;
    dev_next = {{(DIVW-13){1'b0}}, bsz} * {{(DIVW-QW){1'b0}}, nblk_sat};
    pos_w    = {{(DIVW-40){1'b0}}, pos};
    end_full = pos_w + {{(DIVW-32){1'b0}}, len};
    reject_c = (bsz == 13'd0) || (bsz > 13'(brbs_pkg::MAX_BLOCK_BYTES)) ||
               (wr && !writable) || (pos_w >= dev) || (len == 32'd0);
    len_c    = (end_full > dev) ? 32'(dev - pos_w) : len;
    end_c    = pos_w + {{(DIVW-32){1'b0}}, len_c};
    ta       = {rem_a, dvd_a[DIVW-1]};
    tb       = {rem_b, dvd_b[DIVW-1]};
    ge_a     = ta >= {1'b0, bsz};
    ge_b     = tb >= {1'b0, bsz};
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    push       = 1'b0;
    unique case (state)
      brbs_pkg::FR_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = brbs_pkg::FR_CHECK;
      end
      brbs_pkg::FR_CHECK: begin
        state_next = reject_c ? brbs_pkg::FR_PUSH : brbs_pkg::FR_DIV;
      end
      brbs_pkg::FR_DIV: begin
        if (cnt == brbs_pkg::CNTW'(DIVW - 1)) state_next = brbs_pkg::FR_PUSH;
      end
      brbs_pkg::FR_PUSH: begin
        if (!full) begin
          push       = 1'b1;
          state_next = brbs_pkg::FR_IDLE;
        end
      end
      default: state_next = brbs_pkg::FR_IDLE;
    endcase
  end

  always_comb begin
    push_plan.wr     = wr;
    push_plan.reject = reject;
    push_plan.len    = len;
    push_plan.bsz    = bsz;
    push_plan.q1     = dvd_a[QW-1:0];
    push_plan.r1     = rem_a[11:0];
    push_plan.q2     = dvd_b[QW-1:0];
    push_plan.r2     = rem_b[11:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= brbs_pkg::FR_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    dev <= dev_next;
    unique case (state)
      brbs_pkg::FR_IDLE: begin
        wr  <= mode;
        pos <= byte_position;
        len <= request_length;
      end
      brbs_pkg::FR_CHECK: begin
        reject <= reject_c;
        len    <= len_c;
        dvd_a  <= pos_w;
        dvd_b  <= end_c;
        rem_a  <= 13'd0;
        rem_b  <= 13'd0;
        cnt    <= '0;
      end
      brbs_pkg::FR_DIV: begin
        // Restoring division: one quotient bit of each address per cycle.
        rem_a <= ge_a ? 13'(ta - {1'b0, bsz}) : ta[12:0];
        rem_b <= ge_b ? 13'(tb - {1'b0, bsz}) : tb[12:0];
        dvd_a <= {dvd_a[DIVW-2:0], ge_a};
        dvd_b <= {dvd_b[DIVW-2:0], ge_b};
        cnt   <= cnt + 1'b1;
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/brbs_fifo.sv @@
// ----------------------------------------------------------------------------
// brbs_fifo
// Two-entry queue of classified requests between the front and the back.
// ----------------------------------------------------------------------------
module brbs_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  brbs_pkg::plan_t push_plan,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output brbs_pkg::plan_t head
);

  brbs_pkg::plan_t mem [2];
  logic            wptr, rptr;
  logic [1:0]      count;

  assign full       = count == 2'd2;
  assign head_valid = count != 2'd0;
  assign head       = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_plan;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

@@ rtl/brbs_back.sv @@
// ----------------------------------------------------------------------------
// brbs_back
// Turns a classified request into cache, copy and bulk commands, keeps the
// single-block cache tag and drives the registered result port.
// ----------------------------------------------------------------------------
module brbs_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 plan_valid,
  input  brbs_pkg::plan_t      plan,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           command,
  output logic [27:0]          block_number,
  output logic [28:0]          block_run,
  output logic [11:0]          cache_offset,
  output logic [31:0]          buffer_offset,
  output logic [31:0]          byte_count,
  output logic                 last
);

  localparam int QW = brbs_pkg::QW;
  localparam int BW = brbs_pkg::BLOCK_INDEX_BITS;

  brbs_pkg::back_state_t state, state_next;

  logic [BW-1:0] cached;
  logic          cache_valid;

  logic            can;
  logic            load;
  brbs_pkg::cmd_t  ld_cmd;
  logic [BW-1:0]   ld_blk;
  logic [QW-1:0]   ld_run;
  logic [11:0]     ld_coff;
  logic [31:0]     ld_boff;
  logic [31:0]     ld_cnt;
  logic            ld_last;
  logic            set_cache;
  logic [BW-1:0]   set_blk;
  logic            inv;

  logic          hv, tv_raw, tv, bv;
  logic [12:0]   bmo;
  logic [31:0]   hp, xoff;
  logic [QW-1:0] sb1, endb0, endb1;
  logic [QW-1:0] cached_w;

  always_comb begin
    hv       = plan.r1 != 12'd0;
    bmo      = plan.bsz - {1'b0, plan.r1};
    hp       = ({19'd0, bmo} > plan.len) ? plan.len : {19'd0, bmo};
    xoff     = hv ? hp : 32'd0;
    sb1      = plan.q1 + QW'(hv);
    tv_raw   = plan.r2 != 12'd0;
    endb0    = plan.q2 + QW'(tv_raw);
    tv       = tv_raw && (sb1 < endb0);
    endb1    = tv ? plan.q2 : endb0;
    bv       = endb1 > sb1;
    cached_w = {1'b0, cached};
    can      = !out_valid || out_ready;
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    load       = 1'b0;
    ld_cmd     = brbs_pkg::CMD_DONE;
    ld_blk     = '0;
    ld_run     = '0;
    ld_coff    = '0;
    ld_boff    = '0;
    ld_cnt     = '0;
    ld_last    = 1'b0;
    set_cache  = 1'b0;
    set_blk    = '0;
    inv        = 1'b0;
    unique case (state)
      brbs_pkg::BK_IDLE: begin
        if (plan_valid) state_next = plan.reject ? brbs_pkg::BK_DONE : brbs_pkg::BK_HFETCH;
      end
      brbs_pkg::BK_HFETCH: begin
        if (!hv) begin
          state_next = brbs_pkg::BK_TFETCH;
        end else if (cache_valid && cached == plan.q1[BW-1:0]) begin
          state_next = brbs_pkg::BK_HCOPY;
        end else if (can) begin
          load       = 1'b1;
          ld_cmd     = brbs_pkg::CMD_FETCH;
          ld_blk     = plan.q1[BW-1:0];
          set_cache  = 1'b1;
          set_blk    = plan.q1[BW-1:0];
          state_next = brbs_pkg::BK_HCOPY;
        end
      end
      brbs_pkg::BK_HCOPY: begin
        if (can) begin
          load       = 1'b1;
          ld_cmd     = plan.wr ? brbs_pkg::CMD_TO_CACHE : brbs_pkg::CMD_TO_BUF;
          ld_coff    = plan.r1;
          ld_cnt     = hp;
          state_next = plan.wr ? brbs_pkg::BK_HWB : brbs_pkg::BK_TFETCH;
        end
      end
      brbs_pkg::BK_HWB: begin
        if (can) begin
          load       = 1'b1;
          ld_cmd     = brbs_pkg::CMD_WBACK;
          ld_blk     = plan.q1[BW-1:0];
          state_next = brbs_pkg::BK_TFETCH;
        end
      end
      brbs_pkg::BK_TFETCH: begin
        if (!tv) begin
          state_next = brbs_pkg::BK_BULK;
        end else if (cache_valid && cached == plan.q2[BW-1:0]) begin
          state_next = brbs_pkg::BK_TCOPY;
        end else if (can) begin
          load       = 1'b1;
          ld_cmd     = brbs_pkg::CMD_FETCH;
          ld_blk     = plan.q2[BW-1:0];
          set_cache  = 1'b1;
          set_blk    = plan.q2[BW-1:0];
          state_next = brbs_pkg::BK_TCOPY;
        end
      end
      brbs_pkg::BK_TCOPY: begin
        if (can) begin
          load       = 1'b1;
          ld_cmd     = plan.wr ? brbs_pkg::CMD_TO_CACHE : brbs_pkg::CMD_TO_BUF;
          ld_boff    = plan.len - {20'd0, plan.r2};
          ld_cnt     = {20'd0, plan.r2};
          state_next = plan.wr ? brbs_pkg::BK_TWB : brbs_pkg::BK_BULK;
        end
      end
      brbs_pkg::BK_TWB: begin
        if (can) begin
          load       = 1'b1;
          ld_cmd     = brbs_pkg::CMD_WBACK;
          ld_blk     = plan.q2[BW-1:0];
          state_next = brbs_pkg::BK_BULK;
        end
      end
      brbs_pkg::BK_BULK: begin
        if (!bv) begin
          state_next = brbs_pkg::BK_DONE;
        end else if (can) begin
          load       = 1'b1;
          ld_cmd     = plan.wr ? brbs_pkg::CMD_BULK_WR : brbs_pkg::CMD_BULK_RD;
          ld_blk     = sb1[BW-1:0];
          ld_run     = endb1 - sb1;
          ld_boff    = xoff;
          // A bulk write over the cached block leaves the cache stale.
          inv        = plan.wr && cache_valid && (cached_w >= sb1) && (cached_w < endb1);
          state_next = brbs_pkg::BK_DONE;
        end
      end
      brbs_pkg::BK_DONE: begin
        if (can) begin
          load       = 1'b1;
          ld_cmd     = brbs_pkg::CMD_DONE;
          ld_cnt     = plan.reject ? 32'd0 : plan.len;
          ld_last    = 1'b1;
          pop        = 1'b1;
          state_next = brbs_pkg::BK_IDLE;
        end
      end
      default: state_next = brbs_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= brbs_pkg::BK_IDLE;
      out_valid   <= 1'b0;
      cached      <= '0;
      cache_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (set_cache) begin
        cached      <= set_blk;
        cache_valid <= 1'b1;
      end else if (inv) begin
        cache_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      command       <= ld_cmd;
      block_number  <= ld_blk;
      block_run     <= ld_run;
      cache_offset  <= ld_coff;
      buffer_offset <= ld_boff;
      byte_count    <= ld_cnt;
      last          <= ld_last;
    end
  end

endmodule

@@ rtl/byte_range_block_splitter_top.sv @@
// ----------------------------------------------------------------------------
// byte_range_block_splitter_top
// Splits byte range read and write requests into block device commands.
// ----------------------------------------------------------------------------
// A request (mode, byte_position, request_length) is taken on the input
// channel; the block answers with one to eight commands on the output
// channel, the last one always a done item with last high and the accepted
// length in byte_count. Registers are written over the configuration channel
// (index 0 block size, 1 device blocks, 2 writable), which is always ready
// and must only be used while no request is in flight.
// The front latches a request, checks and clamps it, divides the start and
// end addresses bit-serially by the block size, and hands it over; a request
// rejected at the check skips the division. The front takes no new request
// until it has handed over the last one. A two-entry queue lets the front
// work on the next request while the back still emits commands, at most one
// per cycle. Reset empties the queue, drops any pending result, clears the
// cache tag and restores the register defaults. When the receiver stalls,
// the output register holds its command and the back waits; the front keeps
// filling the queue and then stops taking requests.
// ----------------------------------------------------------------------------
module byte_range_block_splitter_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [28:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        mode,
  input  logic [39:0] byte_position,
  input  logic [31:0] request_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  command,
  output logic [27:0] block_number,
  output logic [28:0] block_run,
  output logic [11:0] cache_offset,
  output logic [31:0] buffer_offset,
  output logic [31:0] byte_count,
  output logic        last
);

  logic [12:0]            block_bytes;
  logic [brbs_pkg::QW-1:0] device_blocks;
  logic                   writable;

  logic            push, full, pop, head_valid;
  brbs_pkg::plan_t push_plan, head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_bytes   <= 13'd512;
      device_blocks <= '0;
      writable      <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        brbs_pkg::CFG_BLOCK_BYTES:   block_bytes   <= cfg_data[12:0];
        brbs_pkg::CFG_DEVICE_BLOCKS: device_blocks <= cfg_data[brbs_pkg::QW-1:0];
        brbs_pkg::CFG_WRITABLE:      writable      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  brbs_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .mode           (mode),
    .byte_position  (byte_position),
    .request_length (request_length),
    .bsz            (block_bytes),
    .nblk           (device_blocks),
    .writable       (writable),
    .full           (full),
    .push           (push),
    .push_plan      (push_plan)
  );

  brbs_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_plan  (push_plan),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  brbs_back u_back (
    .clk           (clk),
    .rst           (rst),
    .plan_valid    (head_valid),
    .plan          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .command       (command),
    .block_number  (block_number),
    .block_run     (block_run),
    .cache_offset  (cache_offset),
    .buffer_offset (buffer_offset),
    .byte_count    (byte_count),
    .last          (last)
  );

endmodule

@@ rtl/brbs_checker.sv @@
// ----------------------------------------------------------------------------
// brbs_checker
// Port-level checks on the result channel of the splitter.
// ----------------------------------------------------------------------------
module brbs_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  command,
  input logic [27:0] block_number,
  input logic [28:0] block_run,
  input logic [31:0] byte_count,
  input logic        last
);

  // A stalled result keeps its command and block.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(command) && $stable(block_number))
    else $error("result changed while stalled");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> command == brbs_pkg::CMD_DONE)
    else $error("last on a command other than done");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && command == brbs_pkg::CMD_DONE |-> last && block_number == 28'd0)
    else $error("done without last or with a block number");

  // Bulk transfers always cover at least one block and carry no byte count.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (command == brbs_pkg::CMD_BULK_RD || command == brbs_pkg::CMD_BULK_WR)
    |-> block_run != 29'd0 && byte_count == 32'd0)
    else $error("malformed bulk command");

endmodule

bind byte_range_block_splitter_top brbs_checker u_brbs_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .command      (command),
  .block_number (block_number),
  .block_run    (block_run),
  .byte_count   (byte_count),
  .last         (last)
);
